// File: design/rcpwm_pkg.sv
// ---------------------------------------------------------------------------
// rcpwm_pkg
// Shared types and constants of the rc pulse width monitor.
// ---------------------------------------------------------------------------
`default_nettype none

package rcpwm_pkg;

   // number of pulse input channels
   localparam int CHANNELS     = 3;
   // number of width fields on the result channel
   localparam int OUT_CHANNELS = 3;

   localparam int STAMP_W = 16;
   localparam int COUNT_W = 8;
   localparam int SEC_W   = 16;

   // register file geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [2:0] REG_COUNTER_PERIOD     = 3'd0;
   localparam logic [2:0] REG_MIN_WIDTH          = 3'd1;
   localparam logic [2:0] REG_MAX_WIDTH          = 3'd2;
   localparam logic [2:0] REG_FAILSAFE_THRESHOLD = 3'd3;
   localparam logic [2:0] REG_VALID_RELOAD       = 3'd4;
   localparam logic [2:0] REG_TICKS_PER_SECOND   = 3'd5;

   // register reset values
   localparam logic [STAMP_W-1:0] RST_COUNTER_PERIOD     = 16'd2000;
   localparam logic [STAMP_W-1:0] RST_MIN_WIDTH          = 16'd95;
   localparam logic [STAMP_W-1:0] RST_MAX_WIDTH          = 16'd205;
   localparam logic [STAMP_W-1:0] RST_FAILSAFE_THRESHOLD = 16'd149;
   localparam logic [COUNT_W-1:0] RST_VALID_RELOAD       = 8'd25;
   localparam logic [COUNT_W-1:0] RST_TICKS_PER_SECOND   = 8'd50;

   // request kinds
   localparam logic REQ_EDGE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // width check settings seen by every channel
   typedef struct packed {
      logic [STAMP_W-1:0] counter_period;
      logic [STAMP_W-1:0] min_width;
      logic [STAMP_W-1:0] max_width;
   } chan_cfg_type;

   // per-channel control for one processed request
   typedef struct packed {
      logic               edge_we;
      logic               level;
      logic [STAMP_W-1:0] stamp;
      logic               tick;
   } chan_ctl_type;

endpackage

`default_nettype wire

// File: design/rc_pulse_width_monitor_top.sv
// ---------------------------------------------------------------------------
// rc_pulse_width_monitor_top
// Pulse width monitor for rc servo-style inputs with failsafe and seconds count.
// ---------------------------------------------------------------------------
// tick path: input register, then result register; edge requests give no result
// throughput: one request per cycle unless a tick waits on a stalled result
// side, set by the single-pass update of the channel and frame state
// between the two registers
// reset: synchronous, clears stamps, widths, counters and both stages,
// and loads the register defaults
`default_nettype none

module rc_pulse_width_monitor_top (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_type,
   input  wire  [1:0]                          req_channel,
   input  wire                                 req_level,
   input  wire  [rcpwm_pkg::STAMP_W-1:0]       req_stamp,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [rcpwm_pkg::STAMP_W-1:0]       rsp_width_ch0,
   output logic [rcpwm_pkg::STAMP_W-1:0]       rsp_width_ch1,
   output logic [rcpwm_pkg::STAMP_W-1:0]       rsp_width_ch2,
   output logic                                rsp_pulse_error,
   output logic [rcpwm_pkg::COUNT_W-1:0]       rsp_valid_count,
   output logic                                rsp_signal_ok,
   output logic [rcpwm_pkg::SEC_W-1:0]         rsp_seconds,
   output logic                                rsp_second_mark,
   // register port
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [rcpwm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [rcpwm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rcpwm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import rcpwm_pkg::*;

   // configuration registers
   logic [STAMP_W-1:0] counter_period_ff;
   logic [STAMP_W-1:0] min_width_ff;
   logic [STAMP_W-1:0] max_width_ff;
   logic [STAMP_W-1:0] failsafe_threshold_ff;
   logic [COUNT_W-1:0] valid_reload_ff;
   logic [COUNT_W-1:0] ticks_per_second_ff;
   logic [2:0]         csr_index;
   logic               csr_we;

   // input stage
   logic               s1_valid_ff;
   logic               s1_type_ff;
   logic [1:0]         s1_chan_ff;
   logic               s1_level_ff;
   logic [STAMP_W-1:0] s1_stamp_ff;
   logic               s1_go;
   logic               s1_tick_go;
   logic               out_free;

   // frame state
   logic [COUNT_W-1:0] validity_ff;
   logic [COUNT_W-1:0] validity_in;
   logic [COUNT_W-1:0] phase_ff;
   logic [COUNT_W-1:0] phase_in;
   logic [COUNT_W:0]   phase_sum;
   logic               mark;
   logic [SEC_W-1:0]   seconds_ff;
   logic [SEC_W-1:0]   seconds_in;
   logic               frame_err;

   // channel outputs
   chan_cfg_type       chan_cfg;
   chan_ctl_type       chan_ctl [CHANNELS];
   logic [CHANNELS-1:0] chan_bad;
   logic [STAMP_W-1:0] chan_width [CHANNELS];
   logic [STAMP_W-1:0] out_width [OUT_CHANNELS];

   // result register
   logic               rsp_valid_ff;
   logic [STAMP_W-1:0] rsp_width_ff [OUT_CHANNELS];
   logic               rsp_err_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [SEC_W-1:0]   rsp_seconds_ff;
   logic               rsp_mark_ff;

   // register write decode
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_period_ff     <= RST_COUNTER_PERIOD;
         min_width_ff          <= RST_MIN_WIDTH;
         max_width_ff          <= RST_MAX_WIDTH;
         failsafe_threshold_ff <= RST_FAILSAFE_THRESHOLD;
         valid_reload_ff       <= RST_VALID_RELOAD;
         ticks_per_second_ff   <= RST_TICKS_PER_SECOND;
      end else if (csr_we) begin
         case (csr_index)
            REG_COUNTER_PERIOD:     counter_period_ff     <= csr_pwdata[STAMP_W-1:0];
            REG_MIN_WIDTH:          min_width_ff          <= csr_pwdata[STAMP_W-1:0];
            REG_MAX_WIDTH:          max_width_ff          <= csr_pwdata[STAMP_W-1:0];
            REG_FAILSAFE_THRESHOLD: failsafe_threshold_ff <= csr_pwdata[STAMP_W-1:0];
            REG_VALID_RELOAD:       valid_reload_ff       <= csr_pwdata[COUNT_W-1:0];
            REG_TICKS_PER_SECOND:   ticks_per_second_ff   <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (csr_index)
         REG_COUNTER_PERIOD:     csr_prdata = {16'd0, counter_period_ff};
         REG_MIN_WIDTH:          csr_prdata = {16'd0, min_width_ff};
         REG_MAX_WIDTH:          csr_prdata = {16'd0, max_width_ff};
         REG_FAILSAFE_THRESHOLD: csr_prdata = {16'd0, failsafe_threshold_ff};
         REG_VALID_RELOAD:       csr_prdata = {24'd0, valid_reload_ff};
         REG_TICKS_PER_SECOND:   csr_prdata = {24'd0, ticks_per_second_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // stage handshake: edges never wait, ticks need a free result register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_go      = s1_valid_ff && ((s1_type_ff == REQ_EDGE) || out_free);
   assign s1_tick_go = s1_go && (s1_type_ff == REQ_TICK);
   assign req_stall  = s1_valid_ff && !s1_go;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         s1_type_ff  <= req_type;
         s1_chan_ff  <= req_channel;
         s1_level_ff <= req_level;
         s1_stamp_ff <= req_stamp;
      end
   end

   // channel slices
   assign chan_cfg.counter_period = counter_period_ff;
   assign chan_cfg.min_width      = min_width_ff;
   assign chan_cfg.max_width      = max_width_ff;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      assign chan_ctl[i].edge_we = s1_go && (s1_type_ff == REQ_EDGE)
                                   && (int'(s1_chan_ff) == i);
      assign chan_ctl[i].level   = s1_level_ff;
      assign chan_ctl[i].stamp   = s1_stamp_ff;
      assign chan_ctl[i].tick    = s1_tick_go;

      rcpwm_channel u_chan (
         .clock           (clock),
         .reset           (reset),
         .cfg             (chan_cfg),
         .ctl             (chan_ctl[i]),
         .width_bad       (chan_bad[i]),
         .last_width_next (chan_width[i])
      );
   end

   // result widths, unused outputs read zero
   for (genvar k = 0; k < OUT_CHANNELS; k++) begin : g_out
      if (k < CHANNELS) begin : g_used
         assign out_width[k] = chan_width[k];
      end else begin : g_zero
         assign out_width[k] = '0;
      end
   end

   // frame bookkeeping: seconds phase and validity countdown
   always_comb begin
      frame_err = |chan_bad;
      phase_sum = {1'b0, phase_ff} + {{COUNT_W{1'b0}}, 1'b1};
      mark      = (phase_sum >= {1'b0, ticks_per_second_ff});
      phase_in  = mark ? '0 : phase_sum[COUNT_W-1:0];
      seconds_in = mark ? seconds_ff + 16'd1 : seconds_ff;
      if (frame_err || (chan_width[0] > failsafe_threshold_ff)) begin
         validity_in = (validity_ff != '0) ? validity_ff - 8'd1 : validity_ff;
      end else begin
         validity_in = valid_reload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         validity_ff <= '0;
         phase_ff    <= '0;
         seconds_ff  <= '0;
      end else if (s1_tick_go) begin
         validity_ff <= validity_in;
         phase_ff    <= phase_in;
         seconds_ff  <= seconds_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_tick_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_tick_go) begin
         for (int k = 0; k < OUT_CHANNELS; k++) begin
            rsp_width_ff[k] <= out_width[k];
         end
         rsp_err_ff     <= frame_err;
         rsp_count_ff   <= validity_in;
         rsp_seconds_ff <= seconds_in;
         rsp_mark_ff    <= mark;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_width_ch0   = rsp_width_ff[0];
   assign rsp_width_ch1   = rsp_width_ff[1];
   assign rsp_width_ch2   = rsp_width_ff[2];
   assign rsp_pulse_error = rsp_err_ff;
   assign rsp_valid_count = rsp_count_ff;
   assign rsp_signal_ok   = (rsp_count_ff != '0);
   assign rsp_seconds     = rsp_seconds_ff;
   assign rsp_second_mark = rsp_mark_ff;

   // checks
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && (s1_type_ff == REQ_TICK))
      else $error("request stalled without a waiting tick");

   a_edge_no_result: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_type_ff == REQ_EDGE) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("edge request produced a result");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      s1_tick_go |=> rsp_valid_ff && (rsp_seconds_ff == seconds_ff))
      else $error("tick result missing or seconds mismatch");

endmodule

`default_nettype wire

// File: design/rcpwm_channel.sv
// ---------------------------------------------------------------------------
// rcpwm_channel
// One pulse input: start and end stamps, width check and last good width.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpwm_channel (
   input  wire                              clock,
   input  wire                              reset,
   input  rcpwm_pkg::chan_cfg_type          cfg,
   input  rcpwm_pkg::chan_ctl_type          ctl,
   output logic                             width_bad,
   output logic [rcpwm_pkg::STAMP_W-1:0]    last_width_next
);
   import rcpwm_pkg::*;

   logic [STAMP_W-1:0] start_ff;
   logic [STAMP_W-1:0] end_ff;
   logic [STAMP_W-1:0] last_ff;
   logic [STAMP_W-1:0] end_adj;
   logic [STAMP_W-1:0] width;

   // width with wrap correction, all modulo 2^16
   always_comb begin
      end_adj = (start_ff > end_ff) ? end_ff + cfg.counter_period : end_ff;
      width   = end_adj - start_ff;
      width_bad = (width == '0) || (width < cfg.min_width) || (width > cfg.max_width);
      last_width_next = (ctl.tick && !width_bad) ? width : last_ff;
   end

   // stamp capture on edges, clear on tick
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         last_ff  <= '0;
      end else if (ctl.tick) begin
         start_ff <= '0;
         end_ff   <= '0;
         last_ff  <= last_width_next;
      end else if (ctl.edge_we) begin
         if (ctl.level) begin
            start_ff <= ctl.stamp;
         end else begin
            end_ff <= ctl.stamp;
         end
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/rcpwm_frame_compare.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcpwm_frame_compare
// Watches the request, result and register ports of the pulse width monitor,
// keeps its own copy of the stamps, widths and counters, works out the frame
// result of every accepted tick request and compares it with what comes out.
// ---------------------------------------------------------------------------

module rcpwm_frame_compare (
   input  wire                             clock,
   input  wire                             reset,
   // request channel
   input  wire                             req_valid,
   input  wire                             req_stall,
   input  wire                             req_type,
   input  wire [1:0]                       req_channel,
   input  wire                             req_level,
   input  wire [rcpwm_pkg::STAMP_W-1:0]    req_stamp,
   // result channel
   input  wire                             rsp_valid,
   input  wire                             rsp_stall,
   input  wire [rcpwm_pkg::STAMP_W-1:0]    rsp_width_ch0,
   input  wire [rcpwm_pkg::STAMP_W-1:0]    rsp_width_ch1,
   input  wire [rcpwm_pkg::STAMP_W-1:0]    rsp_width_ch2,
   input  wire                             rsp_pulse_error,
   input  wire [rcpwm_pkg::COUNT_W-1:0]    rsp_valid_count,
   input  wire                             rsp_signal_ok,
   input  wire [rcpwm_pkg::SEC_W-1:0]      rsp_seconds,
   input  wire                             rsp_second_mark,
   // register port
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire [rcpwm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire [rcpwm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire                             csr_pready,
   // totals for the testbench top
   output int                              fail_count,
   output int                              frames_pending,
   output int                              frames_checked
);
   import rcpwm_pkg::*;

   typedef struct packed {
      logic [STAMP_W-1:0] width_ch0;
      logic [STAMP_W-1:0] width_ch1;
      logic [STAMP_W-1:0] width_ch2;
      logic               pulse_error;
      logic [COUNT_W-1:0] valid_count;
      logic               signal_ok;
      logic [SEC_W-1:0]   seconds;
      logic               second_mark;
   } frame_result_type;

   // mirrored registers
   logic [STAMP_W-1:0] period_cfg;
   logic [STAMP_W-1:0] min_cfg;
   logic [STAMP_W-1:0] max_cfg;
   logic [STAMP_W-1:0] thresh_cfg;
   logic [COUNT_W-1:0] reload_cfg;
   logic [COUNT_W-1:0] tps_cfg;

   // mirrored channel and frame state
   logic [STAMP_W-1:0] rise_stamp [CHANNELS];
   logic [STAMP_W-1:0] fall_stamp [CHANNELS];
   logic [STAMP_W-1:0] good_width [CHANNELS];
   logic [COUNT_W-1:0] validity_cnt;
   logic [COUNT_W-1:0] phase_cnt;
   logic [SEC_W-1:0]   sec_cnt;

   frame_result_type   expected_frames [$];
   frame_result_type   want;

   initial begin
      fail_count     = 0;
      frames_pending = 0;
      frames_checked = 0;
   end

   // close one frame: advance the seconds phase, check every channel width,
   // update the failsafe count and clear the stamps
   function automatic frame_result_type close_frame();
      frame_result_type   res;
      logic [8:0]         next_phase;
      logic [STAMP_W-1:0] stop;
      logic [STAMP_W-1:0] width;
      logic [STAMP_W-1:0] shown [OUT_CHANNELS];
      logic               bad;
      int                 i;
      res = '0;
      bad = 1'b0;
      next_phase = {1'b0, phase_cnt} + 9'd1;
      // a period of zero, or a phase left beyond a lowered period, completes a second
      if (next_phase >= {1'b0, tps_cfg}) begin
         next_phase = '0;
         res.second_mark = 1'b1;
         sec_cnt = sec_cnt + 1'b1;
      end
      phase_cnt = next_phase[COUNT_W-1:0];
      for (i = 0; i < CHANNELS; i++) begin
         stop = fall_stamp[i];
         // pulse wrapped past the counter period, all modulo 16 bits
         if (rise_stamp[i] > stop) begin
            stop = stop + period_cfg;
         end
         width = stop - rise_stamp[i];
         if (width == '0 || width < min_cfg || width > max_cfg) begin
            bad = 1'b1;
         end else begin
            good_width[i] = width;
         end
         rise_stamp[i] = '0;
         fall_stamp[i] = '0;
      end
      // failsafe count
      if (bad || good_width[0] > thresh_cfg) begin
         if (validity_cnt != '0) begin
            validity_cnt = validity_cnt - 1'b1;
         end
      end else begin
         validity_cnt = reload_cfg;
      end
      // width fields past the channel count read zero
      for (i = 0; i < OUT_CHANNELS; i++) begin
         shown[i] = (i < CHANNELS) ? good_width[i] : '0;
      end
      res.width_ch0   = shown[0];
      res.width_ch1   = shown[1];
      res.width_ch2   = shown[2];
      res.pulse_error = bad;
      res.valid_count = validity_cnt;
      res.signal_ok   = (validity_cnt != '0);
      res.seconds     = sec_cnt;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         period_cfg   = RST_COUNTER_PERIOD;
         min_cfg      = RST_MIN_WIDTH;
         max_cfg      = RST_MAX_WIDTH;
         thresh_cfg   = RST_FAILSAFE_THRESHOLD;
         reload_cfg   = RST_VALID_RELOAD;
         tps_cfg      = RST_TICKS_PER_SECOND;
         for (int i = 0; i < CHANNELS; i++) begin
            rise_stamp[i] = '0;
            fall_stamp[i] = '0;
            good_width[i] = '0;
         end
         validity_cnt = '0;
         phase_cnt    = '0;
         sec_cnt      = '0;
         expected_frames.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_COUNTER_PERIOD:     period_cfg = csr_pwdata[STAMP_W-1:0];
               REG_MIN_WIDTH:          min_cfg    = csr_pwdata[STAMP_W-1:0];
               REG_MAX_WIDTH:          max_cfg    = csr_pwdata[STAMP_W-1:0];
               REG_FAILSAFE_THRESHOLD: thresh_cfg = csr_pwdata[STAMP_W-1:0];
               REG_VALID_RELOAD:       reload_cfg = csr_pwdata[COUNT_W-1:0];
               REG_TICKS_PER_SECOND:   tps_cfg    = csr_pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         // accepted request: edges store stamps, ticks close a frame
         if (req_valid && !req_stall) begin
            if (req_type == REQ_TICK) begin
               expected_frames.push_back(close_frame());
            end else if (req_channel < CHANNELS) begin
               if (req_level) begin
                  rise_stamp[req_channel] = req_stamp;
               end else begin
                  fall_stamp[req_channel] = req_stamp;
               end
            end
         end
         // accepted result against the oldest expected frame
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: result with no frame expected", $time);
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("width_ch0", 32'(want.width_ch0), 32'(rsp_width_ch0));
               check_field("width_ch1", 32'(want.width_ch1), 32'(rsp_width_ch1));
               check_field("width_ch2", 32'(want.width_ch2), 32'(rsp_width_ch2));
               check_field("pulse_error", 32'(want.pulse_error), 32'(rsp_pulse_error));
               check_field("valid_count", 32'(want.valid_count), 32'(rsp_valid_count));
               check_field("signal_ok", 32'(want.signal_ok), 32'(rsp_signal_ok));
               check_field("seconds", 32'(want.seconds), 32'(rsp_seconds));
               check_field("second_mark", 32'(want.second_mark), 32'(rsp_second_mark));
               frames_checked++;
            end
         end
      end
      frames_pending = expected_frames.size();
   end

endmodule

// File: tb/sv/rc_pulse_width_monitor_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rc_pulse_width_monitor_top_tb
// Drives edge and tick requests into the pulse width monitor under several
// register settings, with bursty requests and a stalling result side, and
// reports the outcome of the frame compare running beside the block.
// ---------------------------------------------------------------------------

module rc_pulse_width_monitor_top_tb;
   import rcpwm_pkg::*;

   localparam int   WATCHDOG_LIMIT = 4000;
   localparam int   HOLD_CYCLES    = 400;
   localparam logic RISE           = 1'b1;
   localparam logic FALL           = 1'b0;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_type;
   logic [1:0]            req_channel;
   logic                  req_level;
   logic [STAMP_W-1:0]    req_stamp;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STAMP_W-1:0]    rsp_width_ch0;
   logic [STAMP_W-1:0]    rsp_width_ch1;
   logic [STAMP_W-1:0]    rsp_width_ch2;
   logic                  rsp_pulse_error;
   logic [COUNT_W-1:0]    rsp_valid_count;
   logic                  rsp_signal_ok;
   logic [SEC_W-1:0]      rsp_seconds;
   logic                  rsp_second_mark;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int frames_pending;
   int frames_checked;

   int burst_left;
   int items_sent;
   int settings_applied;
   int quiet_cycles;
   bit hold_request;
   bit hold_done;

   // register values as last written, used to shape the stimulus
   int cfg_period;
   int cfg_min;
   int cfg_max;

   always #10 clock = ~clock;

   rc_pulse_width_monitor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_channel     (req_channel),
      .req_level       (req_level),
      .req_stamp       (req_stamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_width_ch0   (rsp_width_ch0),
      .rsp_width_ch1   (rsp_width_ch1),
      .rsp_width_ch2   (rsp_width_ch2),
      .rsp_pulse_error (rsp_pulse_error),
      .rsp_valid_count (rsp_valid_count),
      .rsp_signal_ok   (rsp_signal_ok),
      .rsp_seconds     (rsp_seconds),
      .rsp_second_mark (rsp_second_mark),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   rcpwm_frame_compare frame_compare (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_channel     (req_channel),
      .req_level       (req_level),
      .req_stamp       (req_stamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_width_ch0   (rsp_width_ch0),
      .rsp_width_ch1   (rsp_width_ch1),
      .rsp_width_ch2   (rsp_width_ch2),
      .rsp_pulse_error (rsp_pulse_error),
      .rsp_valid_count (rsp_valid_count),
      .rsp_signal_ok   (rsp_signal_ok),
      .rsp_seconds     (rsp_seconds),
      .rsp_second_mark (rsp_second_mark),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .frames_pending  (frames_pending),
      .frames_checked  (frames_checked)
   );

   // watchdog: cycles with no handshake on any port
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // result side stall pattern, with one long hold-off on request
   initial begin : rsp_pacing
      int mode;
      int left;
      int hold;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      mode = 0;
      left = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(32, 256);
         end
         left--;
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 7) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= (left % 3 == 0);
            endcase
         end
      end
   end

   // one request, paced in bursts; returns at the falling edge after acceptance
   task automatic send_request(input logic kind, input logic [1:0] ch, input logic lvl,
                               input logic [STAMP_W-1:0] stamp);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_channel <= ch;
      req_level   <= lvl;
      req_stamp   <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      // edges on a missing channel are ignored by the block
      if (!(kind == REQ_EDGE && ch >= CHANNELS)) begin
         items_sent++;
      end
   endtask

   // stop requests and wait until every frame result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (frames_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input int period, input int minw, input int maxw,
                                 input int thr, input int reload, input int tps);
      drain_results();
      csr_write(REG_COUNTER_PERIOD, period);
      csr_write(REG_MIN_WIDTH, minw);
      csr_write(REG_MAX_WIDTH, maxw);
      csr_write(REG_FAILSAFE_THRESHOLD, thr);
      csr_write(REG_VALID_RELOAD, reload);
      csr_write(REG_TICKS_PER_SECOND, tps);
      cfg_period = period;
      cfg_min    = minw;
      cfg_max    = maxw;
      settings_applied++;
   endtask

   // one random frame: mostly clean pulses on every channel, else noise or broken frames
   task automatic random_frame();
      int kind;
      int i;
      int n;
      int w;
      int start;
      int stop;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         for (i = 0; i < CHANNELS; i++) begin
            if ($urandom_range(0, 19) != 0) begin
               n = $urandom_range(0, 9);
               if (n < 8 && cfg_min <= cfg_max) begin
                  w = $urandom_range(cfg_min, cfg_max);
               end else if (n == 8) begin
                  w = $urandom_range(0, 3);
               end else begin
                  w = $urandom_range(0, 65535);
               end
               start = (cfg_period >= 256) ? $urandom_range(0, cfg_period - 1)
                                           : $urandom_range(0, 65535);
               stop = (start + w) % cfg_period;
               if ($urandom_range(0, 1)) begin
                  send_request(REQ_EDGE, 2'(i), RISE, 16'(start));
                  send_request(REQ_EDGE, 2'(i), FALL, 16'(stop));
               end else begin
                  send_request(REQ_EDGE, 2'(i), FALL, 16'(stop));
                  send_request(REQ_EDGE, 2'(i), RISE, 16'(start));
               end
            end
         end
      end else if (kind == 7) begin
         // raw noise, any channel including the missing one
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) begin
            send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
         end
      end else if (kind == 8) begin
         // broken frame: stray edges before the tick
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            send_request(REQ_EDGE, 2'($urandom_range(0, CHANNELS - 1)),
                         1'($urandom_range(0, 1)),
                         16'((cfg_period >= 256) ? $urandom_range(0, cfg_period - 1)
                                                 : $urandom_range(0, 65535)));
         end
      end
      send_request(REQ_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
   endtask

   task automatic run_random(input int budget);
      int target;
      target = items_sent + budget;
      while (items_sent < target) random_frame();
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_EDGE;
      req_channel      = 2'd0;
      req_level        = FALL;
      req_stamp        = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      hold_request     = 1'b0;
      burst_left       = 0;
      items_sent       = 0;
      settings_applied = 1;
      cfg_period       = int'(RST_COUNTER_PERIOD);
      cfg_min          = int'(RST_MIN_WIDTH);
      cfg_max          = int'(RST_MAX_WIDTH);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // tick with no edges: every channel reads zero width
      send_request(REQ_TICK, 2'd0, FALL, 16'd0);
      // good frame at the minimum and maximum, channel one wraps past the period
      send_request(REQ_EDGE, 2'd0, RISE, 16'd0);
      send_request(REQ_EDGE, 2'd0, FALL, 16'd95);
      send_request(REQ_EDGE, 2'd1, RISE, 16'd1950);
      send_request(REQ_EDGE, 2'd1, FALL, 16'd100);
      send_request(REQ_EDGE, 2'd2, RISE, 16'd100);
      send_request(REQ_EDGE, 2'd2, FALL, 16'd305);
      send_request(REQ_TICK, 2'd3, RISE, 16'hffff);
      // missing channel, overwritten start, width over the failsafe threshold,
      // extreme stamps
      send_request(REQ_EDGE, 2'd3, RISE, 16'd5);
      send_request(REQ_EDGE, 2'd3, FALL, 16'hffff);
      send_request(REQ_EDGE, 2'd0, RISE, 16'd10);
      send_request(REQ_EDGE, 2'd0, RISE, 16'd20);
      send_request(REQ_EDGE, 2'd0, FALL, 16'd180);
      send_request(REQ_EDGE, 2'd1, RISE, 16'hffff);
      send_request(REQ_EDGE, 2'd1, FALL, 16'd0);
      send_request(REQ_TICK, 2'd0, FALL, 16'd0);
      // zero width, one below the minimum, one above the maximum
      send_request(REQ_EDGE, 2'd2, RISE, 16'd300);
      send_request(REQ_EDGE, 2'd2, FALL, 16'd300);
      send_request(REQ_EDGE, 2'd1, RISE, 16'd0);
      send_request(REQ_EDGE, 2'd1, FALL, 16'd94);
      send_request(REQ_EDGE, 2'd0, RISE, 16'd0);
      send_request(REQ_EDGE, 2'd0, FALL, 16'd206);
      send_request(REQ_TICK, 2'd0, FALL, 16'd0);

      run_random(300);
      // widest limits, a second on every tick; long result hold-off here
      apply_settings(65535, 0, 65535, 65535, 255, 1);
      hold_request = 1'b1;
      run_random(325);
      // smallest period, upper-half window, longest second
      apply_settings(1, 32768, 65535, 0, 0, 255);
      run_random(325);
      // period lowered below the running phase
      apply_settings($urandom_range(200, 65535), $urandom_range(0, 300), $urandom_range(300, 600),
                     $urandom_range(0, 600), $urandom_range(0, 255), 3);
      run_random(325);
      // zero ticks per second behaves as one
      apply_settings($urandom_range(200, 65535), $urandom_range(0, 300), $urandom_range(300, 600),
                     $urandom_range(0, 600), $urandom_range(0, 255), 0);
      run_random(325);
      apply_settings($urandom_range(1, 65535), $urandom_range(0, 300), $urandom_range(0, 600),
                     $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(1, 255));
      run_random(325);
      drain_results();

      $display("covered %0d requests over %0d register settings", items_sent, settings_applied);
      $display("%0d frame results compared, %0d mismatches", frames_checked, fail_count);
      if (fail_count == 0 && frames_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/rcpwm_pkg.sv
design/rcpwm_channel.sv
design/rc_pulse_width_monitor_top.sv
tb/sv/rcpwm_frame_compare.sv
tb/sv/rc_pulse_width_monitor_top_tb.sv
